>>> hw/rtl/dafe_pkg.sv
// dafe_pkg: shared widths, region codes, stage payload types and the
// daylight saving rule table for the dst_active_from_epoch block.
// No dependencies.
package dafe_pkg;

   localparam int EPOCH_W     = 32;
   localparam int DAYS_W      = 16;
   localparam int HOUR_W      = 5;
   localparam int MON_W       = 4;
   localparam int MDAY_W      = 5;
   localparam int WDAY_W      = 3;
   localparam int REGION_W    = 4;
   localparam int OFFSET_W    = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UTC_OFFSET = 2'd1;

   localparam logic [REGION_W-1:0] REGION_NONE = 4'd0;
   localparam logic [REGION_W-1:0] REGION_DE   = 4'd1;
   localparam logic [REGION_W-1:0] REGION_US   = 4'd2;
   localparam logic [REGION_W-1:0] REGION_CU   = 4'd3;
   localparam logic [REGION_W-1:0] REGION_MD   = 4'd4;
   localparam logic [REGION_W-1:0] REGION_IL   = 4'd5;
   localparam logic [REGION_W-1:0] REGION_LB   = 4'd6;
   localparam logic [REGION_W-1:0] REGION_EG   = 4'd7;
   localparam logic [REGION_W-1:0] REGION_PS   = 4'd8;
   localparam logic [REGION_W-1:0] REGION_PY   = 4'd9;
   localparam logic [REGION_W-1:0] REGION_CL   = 4'd10;
   localparam logic [REGION_W-1:0] REGION_AU   = 4'd11;
   localparam logic [REGION_W-1:0] REGION_NZ   = 4'd12;

   localparam logic [16:0] SECS_PER_DAY = 17'd86400;

   // day count and hour of day
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [HOUR_W-1:0] hour;
   } day_hour_type;

   // civil date: month from 0, day of month from 1, weekday from Sunday
   typedef struct packed {
      logic [MON_W-1:0]  mon;
      logic [MDAY_W-1:0] mday;
      logic [WDAY_W-1:0] wday;
      logic [HOUR_W-1:0] hour;
   } civil_type;

   typedef struct packed {
      logic [MON_W-1:0]  bm;
      logic [WDAY_W-1:0] bd;
      logic [2:0]        bn;
      logic [HOUR_W-1:0] bh;
      logic [MON_W-1:0]  em;
      logic [WDAY_W-1:0] ed;
      logic [2:0]        en;
      logic [HOUR_W-1:0] eh;
      logic              utc;
      logic              south;
   } rule_type;

   // week number 5 means last; unknown regions give an all-zero rule
   function automatic rule_type rule_of(logic [REGION_W-1:0] region);
      rule_type ru;
      case (region)
         REGION_DE: ru = '{4'd2, 3'd0, 3'd5, 5'd1,  4'd9,  3'd0, 3'd5, 5'd1,  1'b1, 1'b0};
         REGION_US: ru = '{4'd2, 3'd0, 3'd2, 5'd2,  4'd10, 3'd0, 3'd1, 5'd2,  1'b0, 1'b0};
         REGION_CU: ru = '{4'd2, 3'd0, 3'd2, 5'd0,  4'd10, 3'd0, 3'd1, 5'd1,  1'b0, 1'b0};
         REGION_MD: ru = '{4'd2, 3'd0, 3'd5, 5'd2,  4'd9,  3'd0, 3'd5, 5'd3,  1'b0, 1'b0};
         REGION_IL: ru = '{4'd2, 3'd0, 3'd5, 5'd2,  4'd9,  3'd0, 3'd5, 5'd2,  1'b0, 1'b0};
         REGION_LB: ru = '{4'd2, 3'd4, 3'd5, 5'd0,  4'd9,  3'd0, 3'd5, 5'd0,  1'b0, 1'b0};
         REGION_EG: ru = '{4'd3, 3'd5, 3'd5, 5'd0,  4'd9,  3'd4, 3'd5, 5'd24, 1'b0, 1'b0};
         REGION_PS: ru = '{4'd3, 3'd6, 3'd5, 5'd2,  4'd9,  3'd0, 3'd5, 5'd2,  1'b0, 1'b0};
         REGION_PY: ru = '{4'd2, 3'd0, 3'd4, 5'd0,  4'd9,  3'd0, 3'd1, 5'd0,  1'b0, 1'b1};
         REGION_CL: ru = '{4'd3, 3'd6, 3'd1, 5'd24, 4'd8,  3'd6, 3'd1, 5'd24, 1'b1, 1'b1};
         REGION_AU: ru = '{4'd3, 3'd0, 3'd1, 5'd3,  4'd9,  3'd0, 3'd1, 5'd2,  1'b0, 1'b1};
         REGION_NZ: ru = '{4'd3, 3'd0, 3'd1, 5'd2,  4'd8,  3'd0, 3'd5, 5'd2,  1'b1, 1'b1};
         default:   ru = '0;
      endcase
      return ru;
   endfunction

   function automatic logic region_known(logic [REGION_W-1:0] region);
      return (region != REGION_NONE) && (region <= REGION_NZ);
   endfunction

endpackage

>>> hw/rtl/dafe_secs.sv
// dafe_secs: four-stage front end. Applies the region shift, splits the
// seconds count into day number and hour by reciprocal multiplication.
// Depends on dafe_pkg.
module dafe_secs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [31:0]                 in_epoch,
   input  logic [31:0]                 shift,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dafe_pkg::day_hour_type      out_data
);
   import dafe_pkg::*;

   localparam int NSTAGE = 4;
   // floor(2^32 / 675); seconds >> 7 over 675 gives days, at most one low
   localparam logic [22:0] DAY_RECIP  = 23'd6362914;
   // ceil(2^20 / 225); exact for (secs >> 4) < 5400
   localparam logic [12:0] HOUR_RECIP = 13'd4661;

   logic [NSTAGE-1:0] vld_ff, vld_in, rdy;

   logic [31:0]       t1_ff, t1_in;
   logic [31:0]       t2_ff;
   logic [DAYS_W-1:0] est_ff, est_in;
   logic [DAYS_W-1:0] days3_ff, days3_in;
   logic [16:0]       secs_ff, secs_in;
   logic [DAYS_W-1:0] days4_ff;
   logic [HOUR_W-1:0] hour_ff, hour_in;

   logic [47:0] est_prod;
   logic [32:0] day_prod;
   logic [31:0] rem_full;
   logic [17:0] rem;
   logic [25:0] hour_prod;

   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
         if (rdy[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_comb begin
      t1_in     = in_epoch + shift;
      est_prod  = 48'(t1_ff[31:7]) * 48'(DAY_RECIP);
      est_in    = est_prod[47:32];
      day_prod  = 33'(est_ff) * 33'(SECS_PER_DAY);
      rem_full  = t2_ff - day_prod[31:0];
      rem       = rem_full[17:0];
      if (rem >= 18'(SECS_PER_DAY)) begin
         days3_in = est_ff + 16'd1;
         secs_in  = 17'(rem - 18'(SECS_PER_DAY));
      end else begin
         days3_in = est_ff;
         secs_in  = rem[16:0];
      end
      hour_prod = 26'(secs_ff[16:4]) * 26'(HOUR_RECIP);
      hour_in   = hour_prod[24:20];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (rdy[0]) begin
         t1_ff <= t1_in;
      end
      if (rdy[1]) begin
         t2_ff  <= t1_ff;
         est_ff <= est_in;
      end
      if (rdy[2]) begin
         days3_ff <= days3_in;
         secs_ff  <= secs_in;
      end
      if (rdy[3]) begin
         days4_ff <= days3_ff;
         hour_ff  <= hour_in;
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = vld_ff[NSTAGE-1];
   assign out_data.days = days4_ff;
   assign out_data.hour = hour_ff;

   a_secs_in_day: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (secs_ff < SECS_PER_DAY))
      else $error("seconds of day out of range after correction");

endmodule

>>> hw/rtl/dafe_civil.sv
// dafe_civil: seven-stage conversion of a day number to month, day of
// month and weekday (Gregorian, March-based years). Depends on dafe_pkg.
module dafe_civil (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  dafe_pkg::day_hour_type      in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dafe_pkg::civil_type         out_data
);
   import dafe_pkg::*;

   localparam int NSTAGE = 7;
   localparam int DOE_W  = 18;
   localparam int YOE_W  = 9;
   localparam int DOY_W  = 9;
   // day number of 2000-03-01, where the era after the one holding 1970 starts
   localparam logic [DAYS_W-1:0] ERA_SPLIT = 16'd11017;
   localparam logic [DOE_W-1:0]  ERA4_BIAS = 18'd135080;
   localparam logic [17:0] WEEK_RECIP = 18'd149797;  // ceil(2^20 / 7)
   localparam logic [15:0] YEAR_RECIP = 16'd45965;   // ceil(2^24 / 365)
   localparam logic [12:0] MP_RECIP   = 13'd6854;    // ceil(2^20 / 153)

   function automatic logic [DOY_W-1:0] month_start(logic [3:0] mp);
      logic [DOY_W-1:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   logic [NSTAGE-1:0] vld_ff, vld_in, rdy;
   logic [HOUR_W-1:0] hour_ff [NSTAGE];
   logic [WDAY_W-1:0] wday_ff [1:NSTAGE-1];
   logic [DOE_W-1:0]  doe_ff  [1:4];

   // stage 1
   logic [DOE_W-1:0] doe_in;
   logic [16:0]      w_ff, w_in;
   logic [13:0]      q7_ff, q7_in;
   logic [34:0]      q7_prod;
   // stage 2
   logic [WDAY_W-1:0] wday_in;
   logic [16:0]       w7;
   logic [31:0]       a1_prod;
   logic [6:0]        a1_ff, a1_in;
   logic [2:0]        b_ff, b_in;
   logic              cc_ff, cc_in;
   // stage 3
   logic [DOE_W-1:0] num_ff, num_in;
   // stage 4
   logic [33:0]      yoe_prod;
   logic [YOE_W-1:0] yoe_ff, yoe_in;
   // stage 5
   logic [1:0]       yc;
   logic [DOE_W-1:0] ysub, doy_full;
   logic [DOY_W-1:0] doy5_ff, doy_in, doy6_ff;
   // stage 6
   logic [10:0]      mp_x;
   logic [23:0]      mp_prod;
   logic [3:0]       mp_ff, mp_in;
   // stage 7
   logic [DOY_W-1:0]  mday_full;
   logic [MDAY_W-1:0] mday_ff, mday_in;
   logic [MON_W-1:0]  mon_ff, mon_in;

   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
         if (rdy[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_comb begin
      // day of era
      if (in_data.days < ERA_SPLIT) begin
         doe_in = 18'(in_data.days) + ERA4_BIAS;
      end else begin
         doe_in = 18'(in_data.days - ERA_SPLIT);
      end
      // 1970-01-01 was a Thursday
      w_in    = 17'(in_data.days) + 17'd4;
      q7_prod = 35'(w_in) * 35'(WEEK_RECIP);
      q7_in   = q7_prod[33:20];

      w7      = 17'(q7_ff) * 17'd7;
      wday_in = 3'(w_ff - w7);
      a1_prod = 32'(doe_ff[1][17:2]) * 32'(YEAR_RECIP);
      a1_in   = a1_prod[30:24];
      if (doe_ff[1] >= 18'd146096) begin
         b_in = 3'd4;
      end else if (doe_ff[1] >= 18'd109572) begin
         b_in = 3'd3;
      end else if (doe_ff[1] >= 18'd73048) begin
         b_in = 3'd2;
      end else if (doe_ff[1] >= 18'd36524) begin
         b_in = 3'd1;
      end else begin
         b_in = 3'd0;
      end
      cc_in = (doe_ff[1] == 18'd146096);

      num_in = doe_ff[2] - 18'(a1_ff) + 18'(b_ff) - 18'(cc_ff);

      yoe_prod = 34'(num_ff) * 34'(YEAR_RECIP);
      yoe_in   = yoe_prod[32:24];

      if (yoe_ff >= 9'd300) begin
         yc = 2'd3;
      end else if (yoe_ff >= 9'd200) begin
         yc = 2'd2;
      end else if (yoe_ff >= 9'd100) begin
         yc = 2'd1;
      end else begin
         yc = 2'd0;
      end
      ysub     = 18'(yoe_ff) * 18'd365 + 18'(yoe_ff[8:2]) - 18'(yc);
      doy_full = doe_ff[4] - ysub;
      doy_in   = doy_full[DOY_W-1:0];

      mp_x    = 11'(doy5_ff) * 11'd5 + 11'd2;
      mp_prod = 24'(mp_x) * 24'(MP_RECIP);
      mp_in   = mp_prod[23:20];

      mday_full = doy6_ff - month_start(mp_ff) + 9'd1;
      mday_in   = mday_full[MDAY_W-1:0];
      if (mp_ff < 4'd10) begin
         mon_in = mp_ff + 4'd2;
      end else begin
         mon_in = mp_ff - 4'd10;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (rdy[0]) begin
         hour_ff[0] <= in_data.hour;
         doe_ff[1]  <= doe_in;
         w_ff       <= w_in;
         q7_ff      <= q7_in;
      end
      for (int i = 1; i < NSTAGE; i++) begin
         if (rdy[i]) begin
            hour_ff[i] <= hour_ff[i-1];
         end
      end
      if (rdy[1]) begin
         doe_ff[2]  <= doe_ff[1];
         wday_ff[1] <= wday_in;
         a1_ff      <= a1_in;
         b_ff       <= b_in;
         cc_ff      <= cc_in;
      end
      for (int i = 2; i < NSTAGE; i++) begin
         if (rdy[i]) begin
            wday_ff[i] <= wday_ff[i-1];
         end
      end
      if (rdy[2]) begin
         doe_ff[3] <= doe_ff[2];
         num_ff    <= num_in;
      end
      if (rdy[3]) begin
         doe_ff[4] <= doe_ff[3];
         yoe_ff    <= yoe_in;
      end
      if (rdy[4]) begin
         doy5_ff <= doy_in;
      end
      if (rdy[5]) begin
         doy6_ff <= doy5_ff;
         mp_ff   <= mp_in;
      end
      if (rdy[6]) begin
         mday_ff <= mday_in;
         mon_ff  <= mon_in;
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = vld_ff[NSTAGE-1];
   assign out_data.mon  = mon_ff;
   assign out_data.mday = mday_ff;
   assign out_data.wday = wday_ff[NSTAGE-1];
   assign out_data.hour = hour_ff[NSTAGE-1];

   a_civil_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTAGE-1] |-> (mon_ff <= 4'd11) && (mday_ff != 5'd0))
      else $error("civil date out of range");

endmodule

>>> hw/rtl/dafe_rule.sv
// dafe_rule: two-stage rule evaluation. Finds the transition day for the
// current month and decides daylight saving. Depends on dafe_pkg.
module dafe_rule (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dafe_pkg::REGION_W-1:0]   region,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  dafe_pkg::civil_type             in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            out_dst
);
   import dafe_pkg::*;

   localparam int NSTAGE = 2;

   localparam logic [1:0] SPAN_OFF   = 2'd0;
   localparam logic [1:0] SPAN_BEGIN = 2'd1;
   localparam logic [1:0] SPAN_END   = 2'd2;
   localparam logic [1:0] SPAN_ON    = 2'd3;

   // February is never a transition month in the table, so its length
   // is left at 28
   function automatic logic [5:0] month_len(logic [MON_W-1:0] mon);
      logic [5:0] n;
      case (mon)
         4'd1:                      n = 6'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   n = 6'd30;
         default:                   n = 6'd31;
      endcase
      return n;
   endfunction

   logic [NSTAGE-1:0] vld_ff, vld_in, rdy;
   rule_type          ru;

   // stage 1
   logic [MDAY_W-1:0] mday_m1;
   logic [2:0]        mrem;
   logic [3:0]        fsum;
   logic [WDAY_W-1:0] first_ff, first_in;
   logic [5:0]        dim_ff;
   logic [MON_W-1:0]  mon_ff;
   logic [MDAY_W-1:0] mday_ff;
   logic [HOUR_W-1:0] hour_ff;

   // stage 2
   logic              is_begin, is_end;
   logic [1:0]        span_ff, span_in;
   logic [WDAY_W-1:0] wd;
   logic [2:0]        wk;
   logic [3:0]        diff;
   logic [5:0]        d, td_ff, td_in;
   logic [5:0]        md_ff, md_in;
   logic [HOUR_W-1:0] hr_ff, hr_in;
   logic              bump;
   logic              dst;

   assign ru = rule_of(region);

   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
         if (rdy[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_comb begin
      // weekday of the first of the month
      mday_m1 = in_data.mday - 5'd1;
      if (mday_m1 >= 5'd28) begin
         mrem = 3'(mday_m1 - 5'd28);
      end else if (mday_m1 >= 5'd21) begin
         mrem = 3'(mday_m1 - 5'd21);
      end else if (mday_m1 >= 5'd14) begin
         mrem = 3'(mday_m1 - 5'd14);
      end else if (mday_m1 >= 5'd7) begin
         mrem = 3'(mday_m1 - 5'd7);
      end else begin
         mrem = 3'(mday_m1);
      end
      fsum = 4'(in_data.wday) + 4'd7 - 4'(mrem);
      if (fsum >= 4'd7) begin
         first_in = 3'(fsum - 4'd7);
      end else begin
         first_in = 3'(fsum);
      end

      // which part of the season this month is
      is_begin = (mon_ff == ru.bm);
      is_end   = !is_begin && (mon_ff == ru.em);
      if (mon_ff < ru.bm || mon_ff > ru.em) begin
         span_in = SPAN_OFF;
      end else if (is_begin) begin
         span_in = SPAN_BEGIN;
      end else if (is_end) begin
         span_in = SPAN_END;
      end else begin
         span_in = SPAN_ON;
      end

      // n-th given weekday, falling back a week past month end
      wd = is_begin ? ru.bd : ru.ed;
      wk = is_begin ? ru.bn : ru.en;
      if (wd >= first_ff) begin
         diff = 4'(wd) - 4'(first_ff);
      end else begin
         diff = 4'(wd) + 4'd7 - 4'(first_ff);
      end
      d = 6'(wk - 3'd1) * 6'd7 + 6'd1 + 6'(diff);
      if (d > dim_ff) begin
         d = d - 6'd7;
      end
      td_in = d;
      if (is_begin && region == REGION_IL) begin
         td_in = d - 6'd2;
      end else if (is_end && region == REGION_PS) begin
         td_in = d - 6'd1;
      end

      md_in = 6'(mday_ff);
      hr_in = hour_ff;
      // Chile end: midnight counts as the last hour of the day before
      if (is_end && region == REGION_CL && hour_ff == 5'd0) begin
         md_in = md_in - 6'd1;
         hr_in = 5'd23;
      end
      bump = !ru.utc && ((is_begin && ru.south) || (is_end && !ru.south));
      if (bump) begin
         if (hr_in == 5'd23) begin
            hr_in = 5'd0;
            md_in = md_in + 6'd1;
         end else begin
            hr_in = hr_in + 5'd1;
         end
      end

      case (span_ff)
         SPAN_OFF:   dst = 1'b0;
         SPAN_BEGIN: dst = (md_ff < td_ff) ? 1'b0 :
                           (md_ff == td_ff) ? (hr_ff >= ru.bh) : 1'b1;
         SPAN_END:   dst = (md_ff < td_ff) ? 1'b1 :
                           (md_ff == td_ff) ? (hr_ff < ru.eh) : 1'b0;
         SPAN_ON:    dst = 1'b1;
         default:    dst = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (rdy[0]) begin
         first_ff <= first_in;
         dim_ff   <= month_len(in_data.mon);
         mon_ff   <= in_data.mon;
         mday_ff  <= in_data.mday;
         hour_ff  <= in_data.hour;
      end
      if (rdy[1]) begin
         span_ff <= span_in;
         td_ff   <= td_in;
         md_ff   <= md_in;
         hr_ff   <= hr_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NSTAGE-1];
   // southern rules: the span between the months is standard time
   assign out_dst   = region_known(region) && (dst != ru.south);

endmodule

>>> hw/rtl/dst_active_from_epoch.sv
// dst_active_from_epoch: daylight saving check on a Unix seconds count.
// Built as the 13-stage compute pipeline plus the output register; one
// request accepted per cycle unless rsp_tready backs up the result slot.
// Bubbles are squeezed out stage by stage under backpressure.
// Synchronous active-high reset empties the pipeline and clears region and
// utc_offset_hours to 0. Depends on dafe_pkg, dafe_secs, dafe_civil, dafe_rule.
module dst_active_from_epoch (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dafe_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [31:0] epoch_seconds
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dafe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [0] dst_active, [7:1] zero
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dafe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dafe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import dafe_pkg::*;

   // 2^32 - 3 h and +12 h as wrapping offsets
   localparam logic [31:0] CL_SHIFT = 32'hFFFF_D5D0;
   localparam logic [31:0] NZ_SHIFT = 32'd43200;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;

   // configuration registers
   logic [REGION_W-1:0] region_ff, region_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   always_comb begin
      region_in = region_ff;
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REGION:     region_in = csr_data[REGION_W-1:0];
            CSR_UTC_OFFSET: offset_in = csr_data[OFFSET_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= REGION_NONE;
         offset_ff <= '0;
      end else begin
         region_ff <= region_in;
         offset_ff <= offset_in;
      end
   end

   assign csr_ready = 1'b1;

   // Seconds shift ahead of the civil conversion: fixed region shift plus the
   // standard offset for rules counted in local time. It is plain logic, as the user
   // must keep config static while requests are in flight (the block does not check).
   rule_type    cfg_rule;
   logic [31:0] offset_ext, offset_secs, region_shift, shift;

   assign cfg_rule    = rule_of(region_ff);
   assign offset_ext  = {{(32-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};
   assign offset_secs = offset_ext * SECS_PER_HOUR;

   always_comb begin
      case (region_ff)
         REGION_CL: region_shift = CL_SHIFT;
         REGION_NZ: region_shift = NZ_SHIFT;
         default:   region_shift = '0;
      endcase
      shift = cfg_rule.utc ? region_shift : region_shift + offset_secs;
   end

   // pipeline
   logic         secs_valid, secs_ready;
   day_hour_type secs_data;
   logic         civil_valid, civil_ready;
   civil_type    civil_data;
   logic         rule_valid, rule_ready, rule_dst;

   dafe_secs u_secs (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_epoch  (req_tdata[EPOCH_W-1:0]),
      .shift     (shift),
      .out_valid (secs_valid),
      .out_ready (secs_ready),
      .out_data  (secs_data)
   );

   dafe_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (secs_valid),
      .in_ready  (secs_ready),
      .in_data   (secs_data),
      .out_valid (civil_valid),
      .out_ready (civil_ready),
      .out_data  (civil_data)
   );

   dafe_rule u_rule (
      .clock     (clock),
      .reset     (reset),
      .region    (region_ff),
      .in_valid  (civil_valid),
      .in_ready  (civil_ready),
      .in_data   (civil_data),
      .out_valid (rule_valid),
      .out_ready (rule_ready),
      .out_dst   (rule_dst)
   );

   // output register; takes a new result whenever the slot is free or
   // being drained this cycle
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic rsp_dst_ff;

   assign rule_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rule_ready) begin
         rsp_tvalid_in = rule_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (rule_ready) begin
         rsp_dst_ff <= rule_dst;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_dst_ff};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff)
      else $error("result valid straight after reset");

   // the request side can only back up when the result slot is stalled
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid_ff && !rsp_tready))
      else $error("request channel stalled with result slot free");

endmodule
